// ----- sv/sptst_pkg.sv -----
// shared types and constants for the sorted polynomial term store
`default_nettype none

package sptst_pkg;

  localparam int MAX_TERMS = 16;
  localparam int CNT_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int EXP_W     = 8;
  localparam int COEF_W    = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_MERGED   = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_TERM     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_FLAG,
    OP_MERGE,
    OP_INSERT,
    OP_ROTATE,
    OP_CLEAR
  } cell_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_READ,
    S_FLUSH,
    S_CLR
  } state_t;

  typedef struct packed {
    logic                     valid;
    logic [EXP_W-1:0]         expo;
    logic signed [COEF_W-1:0] coef;
  } term_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [EXP_W-1:0]         new_exp;
    logic signed [COEF_W-1:0] new_coef;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ----- sv/sptst_in_if.sv -----
// command channel interface
`default_nettype none

interface sptst_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               command;
  logic signed [31:0]       coefficient;
  logic [7:0]               exponent;

  modport source (output valid, output command, output coefficient, output exponent,
                  input ready);
  modport sink   (input valid, input command, input coefficient, input exponent,
                  output ready);
endinterface

`default_nettype wire

// ----- sv/sptst_out_if.sv -----
// result channel interface
`default_nettype none

interface sptst_out_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic signed [31:0]       term_coefficient;
  logic [7:0]               term_exponent;
  logic                     last;

  modport source (output valid, output status, output term_coefficient,
                  output term_exponent, output last, input ready);
  modport sink   (input valid, input status, input term_coefficient,
                  input term_exponent, input last, output ready);
endinterface

`default_nettype wire

// ----- sv/sorted_polynomial_term_store.sv -----
// top level: command decode, cell chain and result register
//
// channel   dir  handshake          payload
// in_ch     in   valid/ready        command, coefficient, exponent
// out_ch    out  valid/ready        status, term_coefficient, term_exponent, last
//
// insert: compare flags at accept, then merge or shift-in once the result register is free
// clear: the chain empties at accept, the cleared beat follows; unused command: no beat
// read-out: the chain rotates once around through cell 0
// reset empties the chain at once, no clearing pass
// a stalled result beat holds the chain whenever the next step must emit a beat; a new command waits in idle only
`default_nettype none

module sorted_polynomial_term_store (
  input  wire         clk,
  input  wire         rst_n,
  sptst_in_if.sink    in_ch,
  sptst_out_if.source out_ch
);

  localparam int N = sptst_pkg::MAX_TERMS;

  sptst_pkg::state_t           state_r, state_nxt;
  logic [7:0]                  exp_r;
  logic signed [31:0]          coef_r;
  logic [sptst_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  sptst_pkg::term_t            pend_r, pend_nxt;
  logic                        out_valid_r, out_valid_nxt;
  sptst_pkg::status_t          out_status_r, out_status_nxt;
  logic signed [31:0]          out_coef_r, out_coef_nxt;
  logic [7:0]                  out_exp_r, out_exp_nxt;
  logic                        out_last_r, out_last_nxt;

  sptst_pkg::cell_ctl_t        ctl;
  sptst_pkg::term_t            cell_q [N];
  logic [N-1:0]                gt_v;
  logic [N-1:0]                eq_v;
  logic [N-1:0]                valid_v;
  logic signed [31:0]          sum_v [N];
  logic signed [31:0]          sum_or;
  logic                        any_eq;
  logic                        full;
  logic                        in_acc;
  logic                        out_free;
  logic                        emit;
  logic                        cand;
  logic                        rotate_ok;
  logic                        cnt_end;

  // cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    sptst_pkg::term_t left_t;
    logic             left_gt;
    if (i == 0) begin : g_head
      assign left_t  = '0;
      assign left_gt = 1'b1;
    end else begin : g_body
      assign left_t  = cell_q[i-1];
      assign left_gt = gt_v[i-1];
    end
    sptst_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .left    (left_t),
      .left_gt (left_gt),
      .right   (cell_q[(i + 1) % N]),
      .term_o  (cell_q[i]),
      .gt_o    (gt_v[i]),
      .eq_o    (eq_v[i]),
      .sum_o   (sum_v[i])
    );
    assign valid_v[i] = cell_q[i].valid;
  end

  always_comb begin
    sum_or = '0;
    for (int i = 0; i < N; i++) begin
      sum_or = sum_or | sum_v[i];
    end
  end

  assign any_eq    = |eq_v;
  assign full      = cell_q[N-1].valid;
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign cand      = cell_q[0].valid && (cell_q[0].coef != '0);
  assign rotate_ok = !cand || !pend_r.valid || out_free;
  assign cnt_end   = (cnt_r == sptst_pkg::CNT_W'(N - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sptst_pkg::S_IDLE: begin
        if (in_acc) begin
          case (in_ch.command)
            sptst_pkg::CMD_INSERT: state_nxt = sptst_pkg::S_APPLY;
            sptst_pkg::CMD_READ:   state_nxt = sptst_pkg::S_READ;
            sptst_pkg::CMD_CLEAR:  state_nxt = sptst_pkg::S_CLR;
            default:               state_nxt = sptst_pkg::S_IDLE;
          endcase
        end
      end
      sptst_pkg::S_APPLY, sptst_pkg::S_CLR, sptst_pkg::S_FLUSH: begin
        if (out_free) state_nxt = sptst_pkg::S_IDLE;
      end
      sptst_pkg::S_READ: begin
        if (rotate_ok && cnt_end) state_nxt = sptst_pkg::S_FLUSH;
      end
      default: state_nxt = sptst_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    ctl.op         = sptst_pkg::OP_HOLD;
    ctl.new_exp    = exp_r;
    ctl.new_coef   = coef_r;
    emit           = 1'b0;
    out_status_nxt = out_status_r;
    out_coef_nxt   = out_coef_r;
    out_exp_nxt    = out_exp_r;
    out_last_nxt   = out_last_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    case (state_r)
      sptst_pkg::S_IDLE: begin
        ctl.new_exp  = in_ch.exponent;
        ctl.new_coef = in_ch.coefficient;
        cnt_nxt      = '0;
        pend_nxt.valid = 1'b0;
        if (in_acc) begin
          case (in_ch.command)
            sptst_pkg::CMD_INSERT: ctl.op = sptst_pkg::OP_FLAG;
            sptst_pkg::CMD_CLEAR:  ctl.op = sptst_pkg::OP_CLEAR;
            default:               ctl.op = sptst_pkg::OP_HOLD;
          endcase
        end
      end
      sptst_pkg::S_APPLY: begin
        if (out_free) begin
          emit         = 1'b1;
          out_exp_nxt  = exp_r;
          out_last_nxt = 1'b1;
          if (any_eq) begin
            ctl.op         = sptst_pkg::OP_MERGE;
            out_status_nxt = sptst_pkg::ST_MERGED;
            out_coef_nxt   = sum_or;
          end else if (full) begin
            out_status_nxt = sptst_pkg::ST_DROPPED;
            out_coef_nxt   = coef_r;
          end else begin
            ctl.op         = sptst_pkg::OP_INSERT;
            out_status_nxt = sptst_pkg::ST_INSERTED;
            out_coef_nxt   = coef_r;
          end
        end
      end
      sptst_pkg::S_CLR: begin
        if (out_free) begin
          emit           = 1'b1;
          out_status_nxt = sptst_pkg::ST_CLEARED;
          out_coef_nxt   = '0;
          out_exp_nxt    = '0;
          out_last_nxt   = 1'b1;
        end
      end
      sptst_pkg::S_READ: begin
        // hold one term back so the final one can carry last
        if (rotate_ok) begin
          ctl.op  = sptst_pkg::OP_ROTATE;
          cnt_nxt = cnt_r + 1'b1;
          if (cand) begin
            pend_nxt = cell_q[0];
            if (pend_r.valid) begin
              emit           = 1'b1;
              out_status_nxt = sptst_pkg::ST_TERM;
              out_coef_nxt   = pend_r.coef;
              out_exp_nxt    = pend_r.expo;
              out_last_nxt   = 1'b0;
            end
          end
        end
      end
      sptst_pkg::S_FLUSH: begin
        if (out_free) begin
          emit         = 1'b1;
          out_last_nxt = 1'b1;
          if (pend_r.valid) begin
            out_status_nxt = sptst_pkg::ST_TERM;
            out_coef_nxt   = pend_r.coef;
            out_exp_nxt    = pend_r.expo;
          end else begin
            out_status_nxt = sptst_pkg::ST_EMPTY;
            out_coef_nxt   = '0;
            out_exp_nxt    = '0;
          end
        end
      end
      default: begin
        ctl.op = sptst_pkg::OP_HOLD;
      end
    endcase
  end

  assign out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sptst_pkg::S_IDLE;
      out_valid_r  <= 1'b0;
      pend_r.valid <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_r.valid <= pend_nxt.valid;
      cnt_r        <= cnt_nxt;
    end
    if (in_acc) begin
      exp_r  <= in_ch.exponent;
      coef_r <= in_ch.coefficient;
    end
    pend_r.expo  <= pend_nxt.expo;
    pend_r.coef  <= pend_nxt.coef;
    out_status_r <= out_status_nxt;
    out_coef_r   <= out_coef_nxt;
    out_exp_r    <= out_exp_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign in_ch.ready             = (state_r == sptst_pkg::S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.term_coefficient = out_coef_r;
  assign out_ch.term_exponent    = out_exp_r;
  assign out_ch.last             = out_last_r;

  // valid entries form a prefix of the chain whenever it is not mid-rotation
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sptst_pkg::S_READ) |-> (((valid_v >> 1) & ~valid_v) == '0))
    else $error("valid entries not packed at the front");

  // at most one cell can hold the inserted exponent
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sptst_pkg::S_APPLY) |-> $onehot0(eq_v))
    else $error("duplicate exponent in chain");

  // a clear command empties the chain on the next edge
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.command == sptst_pkg::CMD_CLEAR) |=> (valid_v == '0))
    else $error("chain not empty after clear");

  // the read-out rotation never changes the number of stored terms
  a_rotate: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sptst_pkg::S_READ) |=> ($countones(valid_v) == $countones($past(valid_v))))
    else $error("read-out changed stored term count");

endmodule

`default_nettype wire

// ----- sv/sptst_cell.sv -----
// one slot of the term chain: compare flags, merge, shift-in, rotate and clear
`default_nettype none

module sptst_cell (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire sptst_pkg::cell_ctl_t   ctl,
  input  wire sptst_pkg::term_t       left,
  input  wire                         left_gt,
  input  wire sptst_pkg::term_t       right,
  output sptst_pkg::term_t            term_o,
  output logic                        gt_o,
  output logic                        eq_o,
  output logic signed [31:0]          sum_o
);

  sptst_pkg::term_t            term_r, term_nxt;
  logic                        gt_r, gt_nxt;
  logic                        eq_r, eq_nxt;
  logic signed [31:0]          sum;

  assign sum = term_r.coef + ctl.new_coef;

  always_comb begin
    term_nxt = term_r;
    gt_nxt   = gt_r;
    eq_nxt   = eq_r;
    case (ctl.op)
      sptst_pkg::OP_FLAG: begin
        gt_nxt = term_r.valid && (term_r.expo > ctl.new_exp);
        eq_nxt = term_r.valid && (term_r.expo == ctl.new_exp);
      end
      sptst_pkg::OP_MERGE: begin
        if (eq_r) begin
          term_nxt.coef = sum;
        end
      end
      sptst_pkg::OP_INSERT: begin
        // cells above the new exponent stay; the first one below takes the term, the rest shift in from the left
        if (!gt_r) begin
          if (left_gt) begin
            term_nxt.valid = 1'b1;
            term_nxt.expo  = ctl.new_exp;
            term_nxt.coef  = ctl.new_coef;
          end else begin
            term_nxt = left;
          end
        end
      end
      sptst_pkg::OP_ROTATE: begin
        term_nxt = right;
      end
      sptst_pkg::OP_CLEAR: begin
        term_nxt.valid = 1'b0;
      end
      default: begin
        term_nxt = term_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r.valid <= 1'b0;
      gt_r         <= 1'b0;
      eq_r         <= 1'b0;
    end else begin
      term_r.valid <= term_nxt.valid;
      gt_r         <= gt_nxt;
      eq_r         <= eq_nxt;
    end
    term_r.expo <= term_nxt.expo;
    term_r.coef <= term_nxt.coef;
  end

  assign term_o = term_r;
  assign gt_o   = gt_r;
  assign eq_o   = eq_r;
  assign sum_o  = eq_r ? sum : '0;

endmodule

`default_nettype wire

// ----- tb/sv/tb_sorted_polynomial_term_store.sv -----
// self-checking bench for the sorted polynomial term store: directed and random commands
module tb_sorted_polynomial_term_store;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM   = 470;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 4000;

  typedef struct packed {
    logic [2:0]                   status;
    logic [sptst_pkg::COEF_W-1:0] coef;
    logic [sptst_pkg::EXP_W-1:0]  expo;
    logic                         last;
  } term_beat_t;

  // tracks the stored polynomial and the result beats still owed by the block
  class poly_term_scoreboard;
    logic [sptst_pkg::EXP_W-1:0]  term_exp  [sptst_pkg::MAX_TERMS];
    logic [sptst_pkg::COEF_W-1:0] term_coef [sptst_pkg::MAX_TERMS];
    int                           term_count;
    term_beat_t                   awaited_beats[$];
    int                           mismatches;

    function new();
      term_count = 0;
      mismatches = 0;
    endfunction

    function void await_beat(logic [2:0] st, logic [sptst_pkg::COEF_W-1:0] c,
                             logic [sptst_pkg::EXP_W-1:0] e, logic l);
      term_beat_t b;
      b.status = st;
      b.coef   = c;
      b.expo   = e;
      b.last   = l;
      awaited_beats.push_back(b);
    endfunction

    function void apply_command(logic [1:0] cmd, logic [sptst_pkg::COEF_W-1:0] c,
                                logic [sptst_pkg::EXP_W-1:0] e);
      int pos;
      int i;
      int nonzero[$];
      pos = 0;
      case (cmd)
        sptst_pkg::CMD_INSERT: begin
          while (pos < term_count && term_exp[pos] > e)
            pos++;
          if (pos < term_count && term_exp[pos] == e) begin
            term_coef[pos] = term_coef[pos] + c;
            await_beat(sptst_pkg::ST_MERGED, term_coef[pos], e, 1'b1);
          end else if (term_count >= sptst_pkg::MAX_TERMS) begin
            await_beat(sptst_pkg::ST_DROPPED, c, e, 1'b1);
          end else begin
            for (i = term_count; i > pos; i--) begin
              term_exp[i]  = term_exp[i-1];
              term_coef[i] = term_coef[i-1];
            end
            term_exp[pos]  = e;
            term_coef[pos] = c;
            term_count++;
            await_beat(sptst_pkg::ST_INSERTED, c, e, 1'b1);
          end
        end
        sptst_pkg::CMD_READ: begin
          // zero-sum terms keep their slot but are not streamed
          for (i = 0; i < term_count; i++)
            if (term_coef[i] != 0)
              nonzero.push_back(i);
          if (nonzero.size() == 0)
            await_beat(sptst_pkg::ST_EMPTY, '0, '0, 1'b1);
          else
            foreach (nonzero[k])
              await_beat(sptst_pkg::ST_TERM, term_coef[nonzero[k]], term_exp[nonzero[k]],
                         k == nonzero.size() - 1);
        end
        sptst_pkg::CMD_CLEAR: begin
          term_count = 0;
          await_beat(sptst_pkg::ST_CLEARED, '0, '0, 1'b1);
        end
        default: ;  // unused code, no beat and no change
      endcase
    endfunction

    function void check_beat(term_beat_t got);
      term_beat_t want;
      if (awaited_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual status=%0d coef=%0h",
                 $time, got.status, got.coef, " exp=%0d last=%0d", got.expo, got.last);
        mismatches++;
        return;
      end
      want = awaited_beats.pop_front();
      if (got.status != want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
      if (got.coef != want.coef) begin
        $display("%0t: term_coefficient expected %0h actual %0h", $time, want.coef, got.coef);
        mismatches++;
      end
      if (got.expo != want.expo) begin
        $display("%0t: term_exponent expected %0d actual %0d", $time, want.expo, got.expo);
        mismatches++;
      end
      if (got.last != want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  poly_term_scoreboard term_sb;
  int burst_left;
  bit hold_off_request;
  int idle_cycles;

  sptst_in_if  in_ch();
  sptst_out_if out_ch();

  sorted_polynomial_term_store uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // offer one command beat and wait for it to be taken; idle between bursts
  task automatic send_command(input logic [1:0] cmd, input logic [sptst_pkg::COEF_W-1:0] c,
                              input logic [sptst_pkg::EXP_W-1:0] e);
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.coefficient <= c;
    in_ch.exponent    <= e;
    do @(posedge clk); while (!in_ch.ready);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? 15 : $urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // beat monitor: results are checked before the same edge's command is applied
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready)
        term_sb.check_beat({out_ch.status, out_ch.term_coefficient, out_ch.term_exponent,
                            out_ch.last});
      if (in_ch.valid && in_ch.ready)
        term_sb.apply_command(in_ch.command, in_ch.coefficient, in_ch.exponent);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("** sorted_polynomial_term_store: FAILED **");
      $finish;
    end
  end

  // receiver stalls in modes of random length, plus one long hold-off
  initial begin : result_sink
    int mode;
    int span;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_off_request) begin
        hold_off_request = 1'b0;
        repeat (HOLD_LEN) begin
          @(posedge clk);
          out_ch.ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 60);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= $urandom_range(0, 1);
          2: out_ch.ready <= ($urandom_range(0, 9) == 0);
          default: out_ch.ready <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int n_sent;
    int session_left;
    int pick;
    int idx;
    int k;
    logic [sptst_pkg::EXP_W-1:0]  e;
    logic [sptst_pkg::COEF_W-1:0] c;
    logic [sptst_pkg::EXP_W-1:0]  pool[$];

    term_sb           = new();
    burst_left        = 0;
    hold_off_request  = 1'b0;
    idle_cycles       = 0;
    in_ch.valid       = 1'b0;
    in_ch.command     = sptst_pkg::CMD_INSERT;
    in_ch.coefficient = '0;
    in_ch.exponent    = '0;
    rst_n             = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_command(sptst_pkg::CMD_CLEAR, $urandom, 8'($urandom));
    send_command(sptst_pkg::CMD_READ, $urandom, 8'($urandom));  // empty store
    send_command(sptst_pkg::CMD_INSERT, 32'h7fff_ffff, 8'd255);
    send_command(sptst_pkg::CMD_INSERT, 32'h8000_0000, 8'd0);
    send_command(sptst_pkg::CMD_INSERT, 32'h8000_0000, 8'd0);   // wraps to zero
    send_command(sptst_pkg::CMD_INSERT, 32'h0000_0001, 8'd255); // wraps to most negative
    send_command(sptst_pkg::CMD_READ, '0, '0);                  // zero term skipped
    send_command(2'd3, $urandom, 8'($urandom));
    for (k = 1; k <= 14; k++)
      send_command(sptst_pkg::CMD_INSERT, $urandom, 8'(10 * k + 5));
    send_command(sptst_pkg::CMD_INSERT, 32'h1234_5678, 8'd200); // store full
    send_command(sptst_pkg::CMD_INSERT, 32'hffff_ffff, 8'd15);  // merge while full
    send_command(sptst_pkg::CMD_READ, '0, '0);
    send_command(sptst_pkg::CMD_CLEAR, '0, '0);
    send_command(sptst_pkg::CMD_INSERT, 32'd5, 8'd9);
    send_command(sptst_pkg::CMD_INSERT, -32'sd5, 8'd9);
    send_command(sptst_pkg::CMD_READ, '0, '0);                  // only zero terms left

    hold_off_request = 1'b1;
    n_sent = 0;
    while (n_sent < N_RANDOM) begin
      session_left = $urandom_range(8, 50);
      pool.delete();
      repeat ($urandom_range(4, 40)) pool.push_back(8'($urandom_range(0, 255)));
      while (session_left > 0 && n_sent < N_RANDOM) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          send_command(2'd3, $urandom, 8'($urandom));
        end else if (pick < 5) begin
          send_command(sptst_pkg::CMD_CLEAR, $urandom, 8'($urandom));
          n_sent++;
          session_left--;
        end else if (pick < 17) begin
          send_command(sptst_pkg::CMD_READ, $urandom, 8'($urandom));
          n_sent++;
          session_left--;
        end else begin
          if ($urandom_range(0, 99) < 35)
            e = 8'($urandom_range(0, 255));
          else
            e = pool[$urandom_range(0, pool.size() - 1)];
          pick = $urandom_range(0, 99);
          if (pick < 40)
            c = $urandom;
          else if (pick < 70)
            c = $urandom_range(0, 16) - 8;
          else if (pick < 80)
            c = $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
          else if (term_sb.term_count > 0) begin
            // cancel a stored term so its sum becomes zero
            idx = $urandom_range(0, term_sb.term_count - 1);
            e   = term_sb.term_exp[idx];
            c   = -term_sb.term_coef[idx];
          end else
            c = $urandom;
          send_command(sptst_pkg::CMD_INSERT, c, e);
          n_sent++;
          session_left--;
        end
      end
      send_command(sptst_pkg::CMD_CLEAR, $urandom, 8'($urandom));
      n_sent++;
    end

    in_ch.valid <= 1'b0;
    while (term_sb.awaited_beats.size() != 0) @(posedge clk);
    repeat (sptst_pkg::MAX_TERMS + 4) @(posedge clk);
    if (term_sb.mismatches == 0 && term_sb.awaited_beats.size() == 0) begin
      $display("** sorted_polynomial_term_store: PASSED **");
    end else begin
      if (term_sb.awaited_beats.size() != 0)
        $display("%0t: %0d expected beats never arrived", $time, term_sb.awaited_beats.size());
      $display("** sorted_polynomial_term_store: FAILED **");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sptst_pkg.sv
sv/sptst_in_if.sv
sv/sptst_out_if.sv
sv/sptst_cell.sv
sv/sorted_polynomial_term_store.sv
tb/sv/tb_sorted_polynomial_term_store.sv
